// ----- rtl/tprd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tprd_pkg: shared types, constants and functions of the tile row decoder
// Holds the item and pixel word layouts, mode codes, register indexes and
// the per-pixel colour index and channel widening functions.
// ----------------------------------------------------------------------------
package tprd_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int ROW_PIXELS      = 8;
  localparam int PLANE_WORDS     = 4;
  localparam int COL_W           = 3;
  localparam int IDX_W           = 8;
  localparam int COLOR_W         = 15;
  localparam int WORD_W          = 16;
  localparam int CHAN_W          = 5;
  localparam int LEVEL_W         = 8;
  localparam int MODE_W          = 2;
  localparam int PAL_W           = 5;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 5;
  localparam int OUT_DEPTH       = 4;
  localparam int OUT_PTR_W       = 2;
  localparam int OUT_CNT_W       = 3;
  localparam int IN_DEPTH        = 2;
  localparam int IN_CNT_W        = 2;

  // Pixel modes
  localparam logic [MODE_W-1:0] MODE_2BPP  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_4BPP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_8BPP  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SEVEN = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_SELECT = 1'b1;

  // Mode seven extended-background palette and index masks
  localparam logic [PAL_W-1:0] PAL_EXTBG  = 5'd1;
  localparam logic [IDX_W-1:0] MASK_SEVEN = 8'h7f;
  localparam logic [IDX_W-1:0] MASK_FULL  = 8'hff;
  localparam logic [IDX_W-1:0] MASK_2BPP  = 8'h03;
  localparam logic [IDX_W-1:0] MASK_4BPP  = 8'h0f;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_ROW   = 1'b1
  } opcode_t;

  typedef logic [ROW_PIXELS-1:0][WORD_W-1:0] row_words_t;

  typedef struct packed {
    opcode_t              op;
    logic [IDX_W-1:0]     color_index;
    logic [COLOR_W-1:0]   color_value;
    row_words_t           words;
  } item_t;

  typedef struct packed {
    logic [MODE_W-1:0] pixel_mode;
    logic [PAL_W-1:0]  palette_select;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0]   column;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic               last;
  } pixel_t;

  // Widen a 5-bit channel to 8 bits by replicating its top bits
  function automatic logic [LEVEL_W-1:0] widen5(input logic [CHAN_W-1:0] v);
    return {v, v[CHAN_W-1:CHAN_W-3]};
  endfunction

  // Colour memory index of pixel x of a row
  function automatic logic [IDX_W-1:0] pixel_index(input cfg_t cfg,
                                                   input row_words_t w,
                                                   input logic [COL_W-1:0] x);
    logic [IDX_W-1:0] raw;
    logic [IDX_W-1:0] idx;
    raw = '0;
    // gather the even and odd plane bits of each plane pair, MSB is leftmost
    for (int p = 0; p < PLANE_WORDS; p++) begin
      raw[2*p]   = w[p][{1'b0, ~x}];
      raw[2*p+1] = w[p][{1'b1, ~x}];
    end
    case (cfg.pixel_mode)
      MODE_2BPP: idx = (raw & MASK_2BPP) + {1'b0, cfg.palette_select, 2'b00};
      MODE_4BPP: idx = (raw & MASK_4BPP) + {cfg.palette_select[3:0], 4'b0000};
      MODE_8BPP: idx = raw;
      default:   idx = w[x][WORD_W-1:IDX_W]
                       & ((cfg.palette_select == PAL_EXTBG) ? MASK_SEVEN : MASK_FULL);
    endcase
    return idx;
  endfunction

endpackage

// ----- rtl/tprd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tprd_front: input word queue
// Accepts write and row words, tags them by kind and holds them in a
// two-entry queue until the back end takes them.
// ----------------------------------------------------------------------------
module tprd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic            in_opcode,
  input  tprd_pkg::item_t in_item,
  output logic            head_valid,
  output tprd_pkg::item_t head,
  input  logic            head_pop
);
  import tprd_pkg::*;

  item_t               slots [IN_DEPTH];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [IN_CNT_W-1:0] count;
  logic                do_push;
  logic                do_pop;
  item_t               sorted_item;

  assign full       = (count == IN_CNT_W'(IN_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = head_pop && head_valid;

  // Classify the word by its opcode
  always_comb begin
    sorted_item    = in_item;
    sorted_item.op = in_opcode ? OP_ROW : OP_WRITE;
  end

  // Store incoming words
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= sorted_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/tprd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tprd_back: row sequencer and colour memory
// Writes colour entries, and steps a row word through its eight pixels, one
// colour memory read per cycle, while the output queue has room.
// ----------------------------------------------------------------------------
module tprd_back (
  input  logic                               clk,
  input  logic                               rst,
  input  tprd_pkg::cfg_t                     cfg,
  input  logic                               head_valid,
  input  tprd_pkg::item_t                    head,
  output logic                               head_pop,
  input  logic [tprd_pkg::OUT_CNT_W-1:0]     out_count,
  output logic                               out_push,
  output tprd_pkg::pixel_t                   out_word
);
  import tprd_pkg::*;

  logic [COLOR_W-1:0]         colour_memory [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] entry_valid;
  logic [COL_W-1:0]           column;
  logic                       rd_valid;
  logic [COLOR_W-1:0]         rd_data;
  logic                       rd_hit;
  logic [COL_W-1:0]           rd_column;
  logic                       rd_last;
  logic                       room;
  logic                       do_write;
  logic                       do_read;
  logic                       col_last;
  logic [IDX_W-1:0]           rd_index;
  logic [COLOR_W-1:0]         colour;

  // Issue a read only if the queue can take it with the one in flight
  assign room     = (out_count + OUT_CNT_W'(rd_valid)) < OUT_CNT_W'(OUT_DEPTH);
  assign do_write = head_valid && (head.op == OP_WRITE);
  assign do_read  = head_valid && (head.op == OP_ROW) && room;
  assign col_last = (column == COL_W'(ROW_PIXELS - 1));
  assign head_pop = do_write || (do_read && col_last);
  assign rd_index = pixel_index(cfg, head.words, column);

  // Pixel counter, read pipe valid and entry valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      column      <= '0;
      rd_valid    <= 1'b0;
      entry_valid <= '0;
    end else begin
      rd_valid <= do_read;
      if (do_read) begin
        column <= column + 1'b1;
      end
      if (do_write) begin
        entry_valid[head.color_index] <= 1'b1;
      end
    end
  end

  // Colour memory: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (do_write) begin
      colour_memory[head.color_index] <= head.color_value;
    end
    if (do_read) begin
      rd_data   <= colour_memory[rd_index];
      rd_hit    <= entry_valid[rd_index];
      rd_column <= column;
      rd_last   <= col_last;
    end
  end

  // Drop never-written entries to zero and widen the channels
  assign colour          = rd_hit ? rd_data : '0;
  assign out_push        = rd_valid;
  assign out_word.column = rd_column;
  assign out_word.red    = widen5(colour[CHAN_W-1:0]);
  assign out_word.green  = widen5(colour[2*CHAN_W-1:CHAN_W]);
  assign out_word.blue   = widen5(colour[3*CHAN_W-1:2*CHAN_W]);
  assign out_word.last   = rd_last;

endmodule

// ----- rtl/tprd_out_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tprd_out_fifo: pixel word output queue
// Four-entry queue between the back end and the result port; its count
// goes back to the sequencer, which never overfills it.
// ----------------------------------------------------------------------------
module tprd_out_fifo (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  tprd_pkg::pixel_t               push_word,
  input  logic                           pop,
  output logic                           empty,
  output tprd_pkg::pixel_t               head,
  output logic [tprd_pkg::OUT_CNT_W-1:0] count
);
  import tprd_pkg::*;

  pixel_t               slots [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic                 do_pop;

  assign empty  = (count == '0);
  assign head   = slots[rd_ptr];
  assign do_pop = pop && !empty;

  // Store pixel words
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/planar_tile_row_decoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_tile_row_decoder_top: planar tile row decoder
// Decodes one eight-pixel tile row per row word into colour-expanded pixel
// words, and keeps the 256-entry colour memory filled by write words.
//
//   channel   | handshake        | content
//   ----------+------------------+------------------------------------------
//   input     | push / full      | opcode, color_index, color_value, words
//   result    | pop / empty      | pixel_column, levels, last_pixel
//   config    | cfg_we           | cfg_index, cfg_data
//
// A write word takes one colour memory write in the back end; a row word
// takes one colour memory read per pixel. The first pixel passes through
// the input queue, the colour memory read register and the output queue.
// Reset clears the queues, the registers and the colour memory valid bits.
// The back end stalls while the four-entry output queue has no room.
// ----------------------------------------------------------------------------
module planar_tile_row_decoder_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic                               opcode,
  input  logic [tprd_pkg::IDX_W-1:0]         color_index,
  input  logic [tprd_pkg::COLOR_W-1:0]       color_value,
  input  logic [tprd_pkg::WORD_W-1:0]        row_word_0,
  input  logic [tprd_pkg::WORD_W-1:0]        row_word_1,
  input  logic [tprd_pkg::WORD_W-1:0]        row_word_2,
  input  logic [tprd_pkg::WORD_W-1:0]        row_word_3,
  input  logic [tprd_pkg::WORD_W-1:0]        row_word_4,
  input  logic [tprd_pkg::WORD_W-1:0]        row_word_5,
  input  logic [tprd_pkg::WORD_W-1:0]        row_word_6,
  input  logic [tprd_pkg::WORD_W-1:0]        row_word_7,
  output logic                               empty,
  input  logic                               pop,
  output logic [tprd_pkg::COL_W-1:0]         pixel_column,
  output logic [tprd_pkg::LEVEL_W-1:0]       red_level,
  output logic [tprd_pkg::LEVEL_W-1:0]       green_level,
  output logic [tprd_pkg::LEVEL_W-1:0]       blue_level,
  output logic                               last_pixel,
  input  logic                               cfg_we,
  input  logic [tprd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tprd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tprd_pkg::*;

  cfg_t                 cfg;
  item_t                in_item;
  item_t                head;
  logic                 head_valid;
  logic                 head_pop;
  logic                 out_push;
  pixel_t               out_word;
  pixel_t               res_word;
  logic [OUT_CNT_W-1:0] out_count;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PIXEL_MODE:     cfg.pixel_mode     <= cfg_data[MODE_W-1:0];
        CFG_PALETTE_SELECT: cfg.palette_select <= cfg_data[PAL_W-1:0];
        default:            cfg <= cfg;
      endcase
    end
  end

  // Gather the input word
  assign in_item.op          = OP_WRITE;
  assign in_item.color_index = color_index;
  assign in_item.color_value = color_value;
  assign in_item.words       = {row_word_7, row_word_6, row_word_5, row_word_4,
                                row_word_3, row_word_2, row_word_1, row_word_0};

  tprd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .in_opcode  (opcode),
    .in_item    (in_item),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  tprd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .out_count  (out_count),
    .out_push   (out_push),
    .out_word   (out_word)
  );

  tprd_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (out_push),
    .push_word (out_word),
    .pop       (pop),
    .empty     (empty),
    .head      (res_word),
    .count     (out_count)
  );

  assign pixel_column = res_word.column;
  assign red_level    = res_word.red;
  assign green_level  = res_word.green;
  assign blue_level   = res_word.blue;
  assign last_pixel   = res_word.last;

endmodule

// ----- rtl/tprd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tprd_checker: port-level checks of the tile row decoder
// Watches reset behavior and the pixel order of result words.
// ----------------------------------------------------------------------------
module tprd_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               full,
  input logic                               empty,
  input logic                               pop,
  input logic [tprd_pkg::COL_W-1:0]         pixel_column,
  input logic                               last_pixel
);
  import tprd_pkg::*;

  // Reset leaves no result waiting and room for input
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");
  a_reset_room: assert property (@(posedge clk) rst |=> !full)
    else $error("input full right after reset");

  // Last flag marks exactly the rightmost column
  a_last_col: assert property (@(posedge clk) disable iff (rst)
      !empty |-> (last_pixel == (pixel_column == COL_W'(ROW_PIXELS - 1))))
    else $error("last_pixel does not match pixel_column");

  // Within a row, columns follow one another
  a_col_step: assert property (@(posedge clk) disable iff (rst)
      (pop && !empty && !last_pixel) ##1 !empty
      |-> pixel_column == $past(pixel_column) + 3'd1)
    else $error("pixel column skipped or repeated");

  // After a row ends, the next row starts at the left
  a_row_start: assert property (@(posedge clk) disable iff (rst)
      (pop && !empty && last_pixel) ##1 !empty |-> pixel_column == '0)
    else $error("row did not start at column zero");

endmodule

bind planar_tile_row_decoder_top tprd_checker u_tprd_checker (.*);
